### design/rve_pkg.sv
// Shared constants and helpers for the repeat vector expander.
package rve_pkg;

    localparam int PATTERN_BYTES = 256;
    localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
    localparam int PP_W          = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam int MUL_W         = LEN_W + 4;

    localparam int TOTAL_W = 25;
    localparam int COUNT_W = 30;
    localparam int SUM_W   = 30;

    localparam logic [COUNT_W-1:0] COUNT_CEILING = COUNT_W'(99999999);
    localparam logic [TOTAL_W-1:0] LIMIT_RESET   = TOTAL_W'(2 * 1024 * 1024);

    localparam int PREFIX_LEN = 9;

    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_PREFIX  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PATTERN = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SEP     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_EMIT    = 3'd6;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVER      = 2'd2;
    localparam logic [1:0] ST_NOTHING   = 2'd3;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    typedef logic [3:0] nibble_t;

    // Expected character of the vector prefix at a given position.
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h24;  // $
            4'd1:    ch = 8'h54;  // T
            4'd2:    ch = 8'h45;  // E
            4'd3:    ch = 8'h53;  // S
            4'd4:    ch = 8'h54;  // T
            4'd5:    ch = 8'h56;  // V
            4'd6:    ch = 8'h45;  // E
            4'd7:    ch = 8'h43;  // C
            4'd8:    ch = 8'h5B;  // [
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### design/rve_ram.sv
// Generic single-port-write RAM with registered read.
module rve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/repeat_vector_expander_core.sv
// Top level of the repeat vector expander: text parser, pattern store and replay.
//
// Input channel (s_*): each item is either one character of a repeat vector
// text (s_action = 0, s_text_last on the final character) or a pull request
// (s_action = 1). Result channel (m_*): a status item after the final
// character of a vector (ok with total length, malformed, over limit), a
// data item per pull while expanded bytes remain, or a "nothing to pull"
// status otherwise. Non-final characters produce no result.
// size_limit is written over the APB port; the user must do so only while the
// block is idle, which the block does not enforce. Each result is registered
// at the edge that accepts its item, with one item accepted every cycle while the
// result register is free; the parse step, the 9x4 count multiply-accumulate and
// the limit compare are combinational before that edge. The pattern memory read is
// prefetched at the next replay position so a pull finds its byte already registered.
// Reset returns the parser to the prefix phase and size_limit to 2 MiB; the
// pattern memory is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds its item and s_ready
// drops until it is taken; s_ready is high whenever the register is empty or
// being drained in the same cycle.
module repeat_vector_expander_core import rve_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [7:0]         s_text_byte,
    input  logic               s_text_last,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [1:0]         m_status,
    output logic [TOTAL_W-1:0] m_total_length,
    output logic [7:0]         m_data_byte,
    output logic               m_data_last,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // State
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]         prefix_pos_reg, prefix_pos_next;
    logic [LEN_W-1:0]   pat_len_reg, pat_len_next;
    logic               pend_valid_reg, pend_valid_next;
    nibble_t            pend_nib_reg, pend_nib_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] prod_reg, prod_next;
    logic               prod_big_reg, prod_big_next;
    logic               bad_reg, bad_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] emit_pos_reg, emit_pos_next;
    logic [PP_W-1:0]    pat_pos_reg, pat_pos_next;
    logic [TOTAL_W-1:0] limit_reg;

    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [TOTAL_W-1:0] m_total_length_reg, m_total_length_next;
    logic [7:0]         m_data_byte_reg, m_data_byte_next;
    logic               m_data_last_reg, m_data_last_next;

    // Effective state after an implied restart
    logic               restart;
    logic [PHASE_W-1:0] ph0;
    logic [3:0]         pp0;
    logic [LEN_W-1:0]   len0;
    logic               pv0;
    nibble_t            pn0;
    logic [COUNT_W-1:0] cnt0;
    logic [TOTAL_W-1:0] prod0;
    logic               big0;
    logic               bad0;
    logic               full0;

    // Character decode
    logic               accept;
    logic [7:0]         ch;
    logic               is_digit;
    logic               is_hex;
    nibble_t            hex_v;
    nibble_t            mul_op;
    logic [MUL_W-1:0]   mul;
    logic [SUM_W-1:0]   sum;

    // Step results
    logic [PHASE_W-1:0] n_ph;
    logic [3:0]         n_pp;
    logic [LEN_W-1:0]   n_len;
    logic               n_pv;
    nibble_t            n_pn;
    logic [COUNT_W-1:0] n_cnt;
    logic [TOTAL_W-1:0] n_prod;
    logic               n_big;
    logic               n_bad;
    logic               cs_run;
    logic [PHASE_W-1:0] cs_ph;

    // End-of-vector results
    logic               f_bad;
    logic               f_pv;
    nibble_t            f_pn;
    logic [COUNT_W-1:0] f_cnt;
    logic [TOTAL_W-1:0] f_prod;
    logic               f_big;
    logic [1:0]         f_status;

    // Replay
    logic               emitting;
    logic [LEN_W-1:0]   pp_plus;
    logic [TOTAL_W-1:0] ep_plus;
    logic               emit_last;
    logic [7:0]         ram_rdata;
    logic               ram_we;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign ch      = s_text_byte;

    assign restart = (phase_reg == PH_IDLE) || (phase_reg == PH_EMIT);
    assign ph0     = restart ? PH_PREFIX : phase_reg;
    assign pp0     = restart ? 4'd0 : prefix_pos_reg;
    assign len0    = restart ? '0 : pat_len_reg;
    assign pv0     = restart ? 1'b0 : pend_valid_reg;
    assign pn0     = restart ? '0 : pend_nib_reg;
    assign cnt0    = restart ? '0 : count_reg;
    assign prod0   = restart ? '0 : prod_reg;
    assign big0    = restart ? 1'b0 : prod_big_reg;
    assign bad0    = restart ? 1'b0 : bad_reg;
    assign full0   = len0 >= LEN_W'(PATTERN_BYTES);

    always_comb begin
        is_digit = (ch >= CH_0) && (ch <= CH_9);
        is_hex   = 1'b1;
        hex_v    = ch[3:0];
        if (is_digit) begin
            hex_v = ch[3:0];
        end else if ((ch >= CH_LC_A) && (ch <= CH_LC_F)) begin
            hex_v = 4'(ch - CH_LC_A + 8'd10);
        end else if ((ch >= CH_UC_A) && (ch <= CH_UC_F)) begin
            hex_v = 4'(ch - CH_UC_A + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // One shared length-by-digit multiply: a flushed nibble or a count digit.
    assign mul_op = ((ph0 == PH_PATTERN) && !full0) ? (pv0 ? pn0 : hex_v) : ch[3:0];
    assign mul    = MUL_W'(len0) * MUL_W'(mul_op);
    assign sum    = SUM_W'({prod0, 3'b0}) + SUM_W'({prod0, 1'b0}) + SUM_W'(mul);

    always_comb begin
        n_ph   = ph0;
        n_pp   = pp0;
        n_len  = len0;
        n_pv   = pv0;
        n_pn   = pn0;
        n_cnt  = cnt0;
        n_prod = prod0;
        n_big  = big0;
        n_bad  = bad0;
        cs_run = 1'b0;
        cs_ph  = ph0;

        unique case (ph0)
            PH_PREFIX: begin
                if ((pp0 < 4'(PREFIX_LEN)) && (ch == prefix_char(pp0))) begin
                    n_pp = pp0 + 4'd1;
                    if ((n_pp == 4'(PREFIX_LEN)) && !s_text_last) begin
                        n_ph = PH_PATTERN;
                    end
                end else begin
                    n_bad = 1'b1;
                    n_ph  = PH_SKIP;
                end
            end
            PH_PATTERN: begin
                if (full0) begin
                    cs_run = 1'b1;
                    cs_ph  = PH_SEP;
                end else if (!is_hex) begin
                    n_ph = PH_SEP;
                    n_pv = 1'b0;
                    n_pn = '0;
                    // pending decimal nibble starts the count, the separator ends it
                    if (pv0 && (pn0 < 4'd10)) begin
                        n_cnt  = COUNT_W'(pn0);
                        n_prod = TOTAL_W'(mul);
                        n_big  = 1'b0;
                        n_ph   = PH_SKIP;
                    end
                end else if (!pv0) begin
                    n_pv = 1'b1;
                    n_pn = hex_v;
                end else begin
                    n_len = len0 + LEN_W'(1);
                    n_pv  = 1'b0;
                    n_pn  = '0;
                    if (n_len >= LEN_W'(PATTERN_BYTES)) begin
                        n_ph = PH_SEP;
                    end
                end
            end
            PH_SEP, PH_COUNT: begin
                cs_run = 1'b1;
            end
            default: begin
            end
        endcase

        if (cs_run) begin
            if (cs_ph == PH_SEP) begin
                n_ph = PH_SEP;
                if (is_digit) begin
                    n_cnt  = COUNT_W'(ch[3:0]);
                    n_prod = TOTAL_W'(mul);
                    n_big  = 1'b0;
                    n_ph   = PH_COUNT;
                end
            end else if (!is_digit) begin
                n_ph = PH_SKIP;
            end else if (cnt0 > COUNT_CEILING) begin
                n_bad = 1'b1;
                n_ph  = PH_SKIP;
            end else begin
                n_cnt  = {cnt0[COUNT_W-4:0], 3'b0} + {cnt0[COUNT_W-2:0], 1'b0}
                       + COUNT_W'(ch[3:0]);
                n_big  = big0 || (sum[SUM_W-1:TOTAL_W] != '0);
                n_prod = sum[TOTAL_W-1:0];
            end
        end
    end

    // Close out a vector on its final character.
    always_comb begin
        f_bad  = n_bad || (n_ph == PH_PREFIX);
        f_pv   = n_pv;
        f_pn   = n_pn;
        f_cnt  = n_cnt;
        f_prod = n_prod;
        f_big  = n_big;
        if (n_ph == PH_PATTERN) begin
            f_pv = 1'b0;
            f_pn = '0;
            if (n_pv && (n_pn < 4'd10)) begin
                f_cnt  = COUNT_W'(n_pn);
                f_prod = TOTAL_W'(mul);
                f_big  = 1'b0;
            end
        end
        if (f_bad || (n_len == '0) || (f_cnt == '0)) begin
            f_status = ST_MALFORMED;
        end else if (f_big || (f_prod > limit_reg)) begin
            f_status = ST_OVER;
        end else begin
            f_status = ST_OK;
        end
    end

    assign emitting  = (phase_reg == PH_EMIT);
    assign pp_plus   = LEN_W'(pat_pos_reg) + LEN_W'(1);
    assign ep_plus   = emit_pos_reg + TOTAL_W'(1);
    assign emit_last = (ep_plus == total_reg);

    assign ram_we = accept && !s_action && (ph0 == PH_PATTERN) && !full0 && is_hex && pv0;

    always_comb begin
        phase_next      = phase_reg;
        prefix_pos_next = prefix_pos_reg;
        pat_len_next    = pat_len_reg;
        pend_valid_next = pend_valid_reg;
        pend_nib_next   = pend_nib_reg;
        count_next      = count_reg;
        prod_next       = prod_reg;
        prod_big_next   = prod_big_reg;
        bad_next        = bad_reg;
        total_next      = total_reg;
        emit_pos_next   = emit_pos_reg;
        pat_pos_next    = pat_pos_reg;

        m_valid_next        = m_ready ? 1'b0 : m_valid_reg;
        m_kind_next         = m_kind_reg;
        m_status_next       = m_status_reg;
        m_total_length_next = m_total_length_reg;
        m_data_byte_next    = m_data_byte_reg;
        m_data_last_next    = m_data_last_reg;

        if (accept && s_action) begin
            m_valid_next        = 1'b1;
            m_total_length_next = '0;
            if (emitting) begin
                m_kind_next      = KIND_DATA;
                m_status_next    = ST_OK;
                m_data_byte_next = ram_rdata;
                m_data_last_next = emit_last;
                emit_pos_next    = ep_plus;
                pat_pos_next     = (pp_plus >= pat_len_reg) ? '0 : PP_W'(pp_plus);
                if (emit_last) begin
                    phase_next = PH_IDLE;
                end
            end else begin
                m_kind_next      = KIND_STATUS;
                m_status_next    = ST_NOTHING;
                m_data_byte_next = '0;
                m_data_last_next = 1'b0;
            end
        end else if (accept) begin
            phase_next      = n_ph;
            prefix_pos_next = n_pp;
            pat_len_next    = n_len;
            pend_valid_next = n_pv;
            pend_nib_next   = n_pn;
            count_next      = n_cnt;
            prod_next       = n_prod;
            prod_big_next   = n_big;
            bad_next        = n_bad;
            total_next      = '0;
            emit_pos_next   = '0;
            pat_pos_next    = '0;
            if (s_text_last) begin
                pend_valid_next     = f_pv;
                pend_nib_next       = f_pn;
                count_next          = f_cnt;
                prod_next           = f_prod;
                prod_big_next       = f_big;
                bad_next            = f_bad;
                phase_next          = (f_status == ST_OK) ? PH_EMIT : PH_IDLE;
                total_next          = (f_status == ST_OK) ? f_prod : '0;
                m_valid_next        = 1'b1;
                m_kind_next         = KIND_STATUS;
                m_status_next       = f_status;
                m_total_length_next = (f_status == ST_OK) ? f_prod : '0;
                m_data_byte_next    = '0;
                m_data_last_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_PREFIX;
            prefix_pos_reg <= '0;
            pat_len_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_nib_reg   <= '0;
            count_reg      <= '0;
            prod_reg       <= '0;
            prod_big_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            total_reg      <= '0;
            emit_pos_reg   <= '0;
            pat_pos_reg    <= '0;
            limit_reg      <= LIMIT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            prefix_pos_reg <= prefix_pos_next;
            pat_len_reg    <= pat_len_next;
            pend_valid_reg <= pend_valid_next;
            pend_nib_reg   <= pend_nib_next;
            count_reg      <= count_next;
            prod_reg       <= prod_next;
            prod_big_reg   <= prod_big_next;
            bad_reg        <= bad_next;
            total_reg      <= total_next;
            emit_pos_reg   <= emit_pos_next;
            pat_pos_reg    <= pat_pos_next;
            m_valid_reg    <= m_valid_next;
            if (psel && penable && pwrite) begin
                limit_reg <= pwdata[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg         <= m_kind_next;
        m_status_reg       <= m_status_next;
        m_total_length_reg <= m_total_length_next;
        m_data_byte_reg    <= m_data_byte_next;
        m_data_last_reg    <= m_data_last_next;
    end

    // Read address follows the next replay position so the byte is ready for the pull.
    rve_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_BYTES)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (PP_W'(len0)),
        .wdata ({pn0, hex_v}),
        .raddr (pat_pos_next),
        .rdata (ram_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_status       = m_status_reg;
    assign m_total_length = m_total_length_reg;
    assign m_data_byte    = m_data_byte_reg;
    assign m_data_last    = m_data_last_reg;

    assign prdata = (paddr == 2'd0) ? 32'(limit_reg) : 32'(limit_reg);
    assign pready = 1'b1;

endmodule

### bench/repeat_vector_expander_core_tb.sv
// Self-checking testbench for the repeat vector expander core: directed and random vectors.
`timescale 1ns / 1ps

module repeat_vector_expander_core_tb import rve_pkg::*; ();

    localparam int CLK_HALF = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN = -1;
    localparam logic [1:0] REG_SIZE_LIMIT = 2'd0;
    localparam string TAG_TEXT = "$TESTVEC[";

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total;
        logic [7:0]         data;
        logic               last;
    } result_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = 1'b0;
    logic [7:0]         s_text_byte = 8'h00;
    logic               s_text_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_kind;
    logic [1:0]         m_status;
    logic [TOTAL_W-1:0] m_total_length;
    logic [7:0]         m_data_byte;
    logic               m_data_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [1:0]         paddr = 2'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    int send_idle = 21;
    int recv_idle = 52;
    int items_sent = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    result_t    due_results[$];
    logic [7:0] vec_text[$];

    // expander state mirror
    logic [PHASE_W-1:0] vec_phase;
    int unsigned        tag_pos;
    logic [7:0]         pat_mem [PATTERN_BYTES];
    int unsigned        pat_len;
    bit                 nib_held;
    logic [3:0]         nib_val;
    longint unsigned    rep_count;
    bit                 vec_bad;
    int unsigned        exp_total;
    int unsigned        emitted;
    int unsigned        replay_pos;
    logic [TOTAL_W-1:0] limit_shadow;

    repeat_vector_expander_core i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic bit log_mismatch();
        mismatches++;
        return mismatches <= 10;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) return CH_0 + 8'(v);
        return (upper ? CH_UC_A : CH_LC_A) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] sep_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic int bytes_left();
        return (vec_phase == PH_EMIT) ? int'(exp_total - emitted) : 0;
    endfunction

    task automatic clear_vector();
        vec_phase = PH_PREFIX;
        tag_pos = 0;
        pat_len = 0;
        nib_held = 1'b0;
        nib_val = 4'd0;
        rep_count = 0;
        vec_bad = 1'b0;
        exp_total = 0;
        emitted = 0;
        replay_pos = 0;
    endtask

    task automatic count_char(input logic [7:0] c);
        bit digit;
        digit = (c >= CH_0 && c <= CH_9);
        if (vec_phase == PH_SEP) begin
            if (digit) begin
                rep_count = c - CH_0;
                vec_phase = PH_COUNT;
            end
        end else if (vec_phase == PH_COUNT) begin
            if (!digit) begin
                vec_phase = PH_SKIP;
            end else if (rep_count > COUNT_CEILING) begin
                vec_bad = 1'b1;
                vec_phase = PH_SKIP;
            end else begin
                rep_count = rep_count * 10 + (c - CH_0);
            end
        end
    endtask

    // a lone nibble is replayed into the count parser as a character
    task automatic flush_nibble();
        logic [7:0] c;
        if (nib_held) begin
            c = (nib_val < 10) ? CH_0 + 8'(nib_val) : CH_LC_A;
            nib_held = 1'b0;
            nib_val = 4'd0;
            count_char(c);
        end
    endtask

    task automatic pattern_char(input logic [7:0] c);
        int v;
        v = hex_nibble(c);
        if (pat_len >= PATTERN_BYTES) begin
            vec_phase = PH_SEP;
            count_char(c);
        end else if (v < 0) begin
            vec_phase = PH_SEP;
            flush_nibble();
            count_char(c);
        end else if (!nib_held) begin
            nib_held = 1'b1;
            nib_val = 4'(v);
        end else begin
            pat_mem[pat_len] = {nib_val, 4'(v)};
            pat_len++;
            nib_held = 1'b0;
            nib_val = 4'd0;
            if (pat_len >= PATTERN_BYTES) vec_phase = PH_SEP;
        end
    endtask

    task automatic expander_step(input logic act, input logic [7:0] c, input logic last,
                                 output bit has, output result_t r);
        longint unsigned prod;
        r = '0;
        has = 1'b0;
        if (act) begin
            has = 1'b1;
            if (vec_phase == PH_EMIT && emitted < exp_total) begin
                r.kind = KIND_DATA;
                r.status = ST_OK;
                r.data = pat_mem[replay_pos];
                r.last = (emitted + 1 == exp_total);
                emitted++;
                replay_pos++;
                if (replay_pos >= pat_len) replay_pos = 0;
                if (emitted >= exp_total) vec_phase = PH_IDLE;
            end else begin
                r.kind = KIND_STATUS;
                r.status = ST_NOTHING;
            end
            return;
        end
        if (vec_phase == PH_IDLE || vec_phase == PH_EMIT) clear_vector();
        case (vec_phase)
            PH_PREFIX: begin
                if (tag_pos < PREFIX_LEN && c == TAG_TEXT[tag_pos]) begin
                    tag_pos++;
                    if (tag_pos == PREFIX_LEN && !last) vec_phase = PH_PATTERN;
                end else begin
                    vec_bad = 1'b1;
                    vec_phase = PH_SKIP;
                end
            end
            PH_PATTERN: pattern_char(c);
            PH_SEP, PH_COUNT: count_char(c);
            default: ;
        endcase
        if (!last) return;
        has = 1'b1;
        r.kind = KIND_STATUS;
        if (vec_phase == PH_PREFIX) vec_bad = 1'b1;
        if (vec_phase == PH_PATTERN) begin
            vec_phase = PH_SEP;
            flush_nibble();
        end
        if (vec_bad || pat_len == 0 || rep_count == 0) begin
            r.status = ST_MALFORMED;
            vec_phase = PH_IDLE;
        end else begin
            prod = longint'(pat_len) * rep_count;
            if (prod > limit_shadow) begin
                r.status = ST_OVER;
                vec_phase = PH_IDLE;
            end else begin
                exp_total = int'(prod);
                emitted = 0;
                replay_pos = 0;
                r.status = ST_OK;
                r.total = TOTAL_W'(prod);
                vec_phase = PH_EMIT;
            end
        end
    endtask

    // result checker; also drives the receiver's ready
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_status, m_total_length, m_data_byte, m_data_last};
            if (due_results.size() == 0) begin
                if (log_mismatch())
                    $display("%0t: result with nothing expected: kind=%0d status=%0d total=%0d",
                             $time, got.kind, got.status, got.total);
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.status !== want.status ||
                    got.total !== want.total || got.data !== want.data ||
                    got.last !== want.last) begin
                    if (log_mismatch())
                        $display({"%0t: mismatch: expected kind=%0d status=%0d total=%0d ",
                                  "data=%02h last=%0d, got kind=%0d status=%0d total=%0d ",
                                  "data=%02h last=%0d"}, $time,
                                 want.kind, want.status, want.total, want.data, want.last,
                                 got.kind, got.status, got.total, got.data, got.last);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [7:0] c, input logic last);
        result_t r;
        bit has;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_text_byte <= c;
        s_text_last <= last;
        do @(posedge aclk); while (!s_ready);
        expander_step(act, c, last, has, r);
        if (has) due_results.push_back(r);
        items_sent++;
    endtask

    task automatic send_pull();
        send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) vec_text.push_back(s[i]);
    endtask

    task automatic add_hex(input logic [7:0] b, input bit upper);
        vec_text.push_back(hex_char(b[7:4], upper));
        vec_text.push_back(hex_char(b[3:0], upper));
    endtask

    task automatic add_pattern(input int n);
        repeat (n) add_hex(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic send_vector(input int pull_pct);
        foreach (vec_text[i]) begin
            if ($urandom_range(99) < pull_pct) send_pull();
            send_item(1'b0, vec_text[i], i == vec_text.size() - 1);
        end
        vec_text.delete();
    endtask

    task automatic run_text(input string s, input int pulls);
        int n;
        add_text(s);
        send_vector(0);
        n = (pulls < 0) ? bytes_left() + 1 : pulls;
        repeat (n) send_pull();
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // write size_limit, then read it back
    task automatic write_limit(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_SIZE_LIMIT;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        limit_shadow = v[TOTAL_W-1:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[TOTAL_W-1:0] !== limit_shadow && log_mismatch())
            $display("%0t: size_limit read back %0d, expected %0d",
                     $time, prdata[TOTAL_W-1:0], limit_shadow);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_basic_expansion();
        send_pull();
        run_text("$TESTVEC[ab]3", DRAIN);
        add_text(TAG_TEXT);
        add_hex(8'h00, 1'b1);
        add_hex(8'hFF, 1'b1);
        add_hex(8'hFF, 1'b0);
        run_text("]x2", DRAIN);
        run_text("$TESTVEC[ab3]", DRAIN);
        run_text("$TESTVEC[abc]x5", DRAIN);
        run_text("$TESTVEC[01]4]z7", DRAIN);
        add_text("$TESTVEC[5a]2");
        send_vector(40);
        repeat (bytes_left() + 1) send_pull();
        // new vector drops the bytes still owed
        run_text("$TESTVEC[1234]9", 5);
        run_text("$TESTVEC[77]1", DRAIN);
    endtask

    task automatic test_malformed_vectors();
        run_text("$TESTVEX[ab]2", 1);
        run_text("$TES", 1);
        run_text("$TESTVEC[", 1);
        run_text("$TESTVEC[]5", 1);
        run_text("$TESTVEC[ab]", 1);
        run_text("$TESTVEC[ab]0", 1);
        run_text("$TESTVEC[ab]1000000000", 1);
        run_text("$TESTVEC[ab]999999999", 1);
        vec_text.push_back(8'hFF);
        run_text("", 1);
        vec_text.push_back(8'h00);
        run_text("", 1);
    endtask

    task automatic test_full_pattern();
        add_text(TAG_TEXT);
        add_pattern(PATTERN_BYTES);
        run_text("7", 12);
    endtask

    task automatic test_size_limit();
        wait_results();
        write_limit(32'd0);
        run_text("$TESTVEC[01]1", 1);
        wait_results();
        write_limit(32'd1);
        run_text("$TESTVEC[01]1", DRAIN);
        run_text("$TESTVEC[01]2", 1);
        wait_results();
        write_limit(32'd16777216);
        run_text("$TESTVEC[0102]8388608", 20);
        run_text("$TESTVEC[0102]8388609", 1);
        wait_results();
        write_limit(32'hFFFF_FFFF);
        run_text("$TESTVEC[010203]11184810", 5);
        run_text("$TESTVEC[ab]33554432", 1);
    endtask

    task automatic random_vector();
        int r, n, left, pulls;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) vec_text.push_back(8'($urandom_range(255)));
        end else begin
            add_text(TAG_TEXT);
            r = $urandom_range(99);
            n = (r < 4) ? 0 :
                (r < 5) ? $urandom_range(PATTERN_BYTES - 8, PATTERN_BYTES) :
                $urandom_range(1, 6);
            add_pattern(n);
            if ($urandom_range(9) == 0)
                vec_text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            repeat (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3))
                vec_text.push_back(sep_char());
            r = $urandom_range(99);
            if (r < 5)
                add_text("0");
            else if (r < 10)
                add_text($sformatf("%0d%0d", $urandom_range(1, 99999),
                                   $urandom_range(10000, 999999)));
            else if (r < 25)
                add_text($sformatf("%0d", $urandom_range(1, 5000)));
            else
                add_text($sformatf("%0d", $urandom_range(1, 12)));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 4)) vec_text.push_back(8'($urandom_range(255)));
            if ($urandom_range(11) == 0)
                vec_text[$urandom_range(vec_text.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(19) == 0)
                vec_text = vec_text[0:$urandom_range(vec_text.size() - 1)];
        end
        send_vector(3);
        left = bytes_left();
        if (left <= 80 && $urandom_range(3) != 0)
            pulls = left + $urandom_range(2);
        else
            pulls = $urandom_range(0, 40);
        repeat (pulls) send_pull();
    endtask

    task automatic test_random_traffic();
        int stop;
        for (int p = 0; p < 3; p++) begin
            wait_results();
            case (p)
                0: begin
                    send_idle = 21;
                    recv_idle = 52;
                    write_limit(32'($urandom_range(16, 300)));
                end
                1: begin
                    send_idle = 52;
                    recv_idle = 21;
                    write_limit(32'(LIMIT_RESET));
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_limit(32'h01FF_FFFF);
                end
            endcase
            stop = items_sent + 100;
            while (items_sent < stop) random_vector();
        end
    endtask

    initial begin
        for (int i = 0; i < PATTERN_BYTES; i++) pat_mem[i] = 8'h00;
        limit_shadow = LIMIT_RESET;
        clear_vector();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_expansion();
        test_malformed_vectors();
        test_full_pattern();
        test_size_limit();
        test_random_traffic();
        wait_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
design/rve_pkg.sv
design/rve_ram.sv
design/repeat_vector_expander_core.sv
bench/repeat_vector_expander_core_tb.sv
